>>> rtl/tst_pkg.sv
`default_nettype none
package tst_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int AMP_WIDTH   = 13;
	localparam int VOL_WIDTH   = 16;
	localparam int NORM_WIDTH  = 16;
	localparam int NORM_ONE    = 16384;
	// magnitudes are brought below 2^LIMIT_BITS before multiplying or squaring
	localparam int LIMIT_BITS  = 30;
	localparam int ROOT_W      = LIMIT_BITS + 1;
	localparam int SQ_W        = 2 * ROOT_W;
	localparam int QUO_W       = 15;

	localparam logic [AMP_WIDTH-1:0] AMP_RESET = AMP_WIDTH'(1280);

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] ax;
		logic signed [COORD_WIDTH-1:0] ay;
		logic signed [COORD_WIDTH-1:0] az;
		logic signed [COORD_WIDTH-1:0] bx;
		logic signed [COORD_WIDTH-1:0] by_coord;
		logic signed [COORD_WIDTH-1:0] bz;
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
		logic signed [COORD_WIDTH-1:0] cz;
		logic        [VOL_WIDTH-1:0]   volume;
	} tst_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] centroid_x;
		logic signed [COORD_WIDTH-1:0] centroid_y;
		logic signed [COORD_WIDTH-1:0] centroid_z;
		logic signed [NORM_WIDTH-1:0]  normal_x;
		logic signed [NORM_WIDTH-1:0]  normal_y;
		logic signed [NORM_WIDTH-1:0]  normal_z;
		logic signed [COORD_WIDTH-1:0] tip_x;
		logic signed [COORD_WIDTH-1:0] tip_y;
		logic signed [COORD_WIDTH-1:0] tip_z;
	} tst_out_t;

	typedef struct packed {
		logic adv;
		logic valid;
	} tst_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/tst_norm_pipe.sv
`default_nettype none
module tst_norm_pipe #(
	parameter int SIDE_W = 1
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire tst_pkg::tst_ctrl_t                            ctrl,
	input  wire logic [tst_pkg::SQ_W-1:0]                      sum,
	input  wire logic [2:0][tst_pkg::LIMIT_BITS-1:0]           mag,
	input  wire logic [SIDE_W-1:0]                             side_in,
	output logic                                               out_valid,
	output logic [2:0][tst_pkg::QUO_W-1:0]                     quo,
	output logic [SIDE_W-1:0]                                  side_out
);

	localparam int RW    = tst_pkg::ROOT_W;
	localparam int REM_W = RW + 2;
	localparam int SQW   = tst_pkg::SQ_W;
	localparam int LW    = tst_pkg::LIMIT_BITS;
	localparam int QW    = tst_pkg::QUO_W;
	localparam int DNW   = RW + 1;
	localparam int DVW   = LW + QW + 1;

	// square root, one result bit per stage
	logic                 rt_v_s    [0:RW];
	logic [SQW-1:0]       rt_x_s    [0:RW];
	logic [REM_W-1:0]     rt_rem_s  [0:RW];
	logic [RW-1:0]        rt_root_s [0:RW];
	logic [2:0][LW-1:0]   rt_mag_s  [0:RW];
	logic [SIDE_W-1:0]    rt_side_s [0:RW];

	assign rt_v_s[0]    = ctrl.valid;
	assign rt_x_s[0]    = sum;
	assign rt_rem_s[0]  = '0;
	assign rt_root_s[0] = '0;
	assign rt_mag_s[0]  = mag;
	assign rt_side_s[0] = side_in;

	for (genvar k = 0; k < RW; k++) begin : g_root
		logic [REM_W-1:0] rem_n;
		logic [REM_W-1:0] trial;
		logic             ge;

		assign rem_n = {rt_rem_s[k][REM_W-3:0], rt_x_s[k][SQW-1 -: 2]};
		assign trial = {rt_root_s[k], 2'b01};
		assign ge    = (rem_n >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else if (ctrl.adv) begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ctrl.adv) begin
				rt_x_s[k+1]    <= {rt_x_s[k][SQW-3:0], 2'b00};
				rt_rem_s[k+1]  <= ge ? (rem_n - trial) : rem_n;
				rt_root_s[k+1] <= {rt_root_s[k][RW-2:0], ge};
				rt_mag_s[k+1]  <= rt_mag_s[k];
				rt_side_s[k+1] <= rt_side_s[k];
			end
		end
	end

	// rounded quotient mag*2^14/len, one bit per stage, three lanes
	logic                 dv_v_s    [0:QW];
	logic [DNW-1:0]       dv_den_s  [0:QW];
	logic [2:0][DVW-1:0]  dv_rem_s  [0:QW];
	logic [2:0][QW-1:0]   dv_q_s    [0:QW];
	logic [SIDE_W-1:0]    dv_side_s [0:QW];

	assign dv_v_s[0]    = rt_v_s[RW];
	assign dv_den_s[0]  = {rt_root_s[RW], 1'b0};
	assign dv_q_s[0]    = '0;
	assign dv_side_s[0] = rt_side_s[RW];

	for (genvar i = 0; i < 3; i++) begin : g_num
		assign dv_rem_s[0][i] = DVW'({rt_mag_s[RW][i], {QW{1'b0}}}) + DVW'(rt_root_s[RW]);
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int B = QW - 1 - k;
		logic [DVW-1:0]      dsh;
		logic [2:0][DVW-1:0] rem_n;
		logic [2:0][QW-1:0]  q_n;

		assign dsh = DVW'(dv_den_s[k]) << B;

		always_comb begin
			rem_n = dv_rem_s[k];
			q_n   = dv_q_s[k];
			for (int i = 0; i < 3; i++) begin
				if (dv_rem_s[k][i] >= dsh) begin
					rem_n[i] = dv_rem_s[k][i] - dsh;
					q_n[i][B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (ctrl.adv) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ctrl.adv) begin
				dv_den_s[k+1]  <= dv_den_s[k];
				dv_rem_s[k+1]  <= rem_n;
				dv_q_s[k+1]    <= q_n;
				dv_side_s[k+1] <= dv_side_s[k];
			end
		end
	end

	assign out_valid = dv_v_s[QW];
	assign quo       = dv_q_s[QW];
	assign side_out  = dv_side_s[QW];

endmodule
`default_nettype wire

>>> rtl/triangle_spike_tip_unit.sv
// Channel   Direction  Handshake              Payload
// tri       in         tri_valid / tri_ready  tst_in_t: vertices A, B, C and volume
// res       out        res_valid / res_ready  tst_out_t: centroid, normal, tip
// cfg       in         cfg_valid / cfg_ready  amplitude, Q5.8
//
// One triangle per cycle while the output register is not stalled; 7 front stages (sums,
// differences, cross product, squares), 31 square root stages, 15 divider stages, 3 tip stages.
// The square root and the normalising divider each retire one bit per stage.
// arst_n clears every valid bit and loads the amplitude with its reset value.
// A stall at the output register freezes the whole pipeline; tri_ready is low
// while the output register holds a beat that is not being taken.
`default_nettype none
module triangle_spike_tip_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              tri_valid,
	output logic                                   tri_ready,
	input  wire tst_pkg::tst_in_t                  tri_data,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output tst_pkg::tst_out_t                      res_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tst_pkg::AMP_WIDTH-1:0]     cfg_data
);

	localparam int W      = tst_pkg::COORD_WIDTH;
	localparam int LIM    = tst_pkg::LIMIT_BITS;
	localparam int SW     = W + 2;
	localparam int DW     = W + 1;
	localparam int XW     = W + 1;
	localparam int MW     = (DW > LIM) ? LIM : DW;
	localparam int CRW    = 2 * MW + 2;
	localparam int CW     = 2 * MW + 1;
	localparam int SH1_MX = (DW > LIM) ? (DW - LIM) : 0;
	localparam int SH1_W  = (SH1_MX < 1) ? 1 : $clog2(SH1_MX + 1);
	localparam int SH2_MX = (CW > LIM) ? (CW - LIM) : 0;
	localparam int SH2_W  = (SH2_MX < 1) ? 1 : $clog2(SH2_MX + 1);
	localparam int SQW    = tst_pkg::SQ_W;
	localparam int VW     = tst_pkg::VOL_WIDTH;
	localparam int AW     = tst_pkg::AMP_WIDTH;
	localparam int NW     = tst_pkg::NORM_WIDTH;
	localparam int QW     = tst_pkg::QUO_W;
	localparam int VPW    = VW + AW;
	localparam int PRW    = VPW + QW;
	localparam int TW     = W + 2;
	// x / 3 == (x * ceil(2^(XW+1) / 3)) >> (XW+1) for every x below 2^XW
	localparam int               RCP_SH = XW + 1;
	localparam longint           RCP_L  = ((longint'(1) << RCP_SH) + 2) / 3;
	localparam logic [XW-1:0]    RCP_3  = XW'(RCP_L);
	localparam int SIDE_W = 3 * W + 3 + 1 + VW;

	logic adv;
	logic [AW-1:0] amp_q;

	assign adv       = !res_valid || res_ready;
	assign tri_ready = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= tst_pkg::AMP_RESET;
		end else if (cfg_valid) begin
			amp_q <= cfg_data;
		end
	end

	// ---------------- S1: vertex sums and edge differences
	logic signed [W-1:0] pa [3];
	logic signed [W-1:0] pb [3];
	logic signed [W-1:0] pc [3];

	assign pa[0] = tri_data.ax;
	assign pa[1] = tri_data.ay;
	assign pa[2] = tri_data.az;
	assign pb[0] = tri_data.bx;
	assign pb[1] = tri_data.by_coord;
	assign pb[2] = tri_data.bz;
	assign pc[0] = tri_data.cx;
	assign pc[1] = tri_data.cy;
	assign pc[2] = tri_data.cz;

	logic                 v_s1;
	logic signed [SW-1:0] sum_s1 [3];
	logic signed [DW-1:0] d1_s1  [3];
	logic signed [DW-1:0] d2_s1  [3];
	logic [VW-1:0]        vol_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= tri_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sum_s1[i] <= {{2{pa[i][W-1]}}, pa[i]} + {{2{pb[i][W-1]}}, pb[i]}
					+ {{2{pc[i][W-1]}}, pc[i]};
				d1_s1[i]  <= {pb[i][W-1], pb[i]} - {pa[i][W-1], pa[i]};
				d2_s1[i]  <= {pc[i][W-1], pc[i]} - {pa[i][W-1], pa[i]};
			end
			vol_s1 <= tri_data.volume;
		end
	end

	// ---------------- S2: bring edge magnitudes below the multiplier limit
	logic [DW-1:0]    ma1 [3];
	logic [DW-1:0]    ma2 [3];
	logic [DW-1:0]    om1;
	logic [SH1_W-1:0] sh1;

	always_comb begin
		om1 = '0;
		for (int i = 0; i < 3; i++) begin
			ma1[i] = d1_s1[i][DW-1] ? DW'(-d1_s1[i]) : DW'(d1_s1[i]);
			ma2[i] = d2_s1[i][DW-1] ? DW'(-d2_s1[i]) : DW'(d2_s1[i]);
			om1    = om1 | ma1[i] | ma2[i];
		end
		sh1 = '0;
		for (int b = LIM; b < DW; b++) begin
			if (om1[b]) sh1 = SH1_W'(b - LIM + 1);
		end
	end

	logic          v_s2;
	logic [MW-1:0] m1_s2 [3];
	logic [MW-1:0] m2_s2 [3];
	logic          n1_s2 [3];
	logic          n2_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				m1_s2[i] <= MW'(ma1[i] >> sh1);
				m2_s2[i] <= MW'(ma2[i] >> sh1);
				n1_s2[i] <= d1_s1[i][DW-1];
				n2_s2[i] <= d2_s1[i][DW-1];
			end
		end
	end

	// ---------------- S3: the six cross product terms
	logic            v_s3;
	logic [2*MW-1:0] pma_s3 [3];
	logic [2*MW-1:0] pmb_s3 [3];
	logic            pna_s3 [3];
	logic            pnb_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pma_s3[i] <= (2*MW)'(m1_s2[(i+1)%3]) * (2*MW)'(m2_s2[(i+2)%3]);
				pmb_s3[i] <= (2*MW)'(m1_s2[(i+2)%3]) * (2*MW)'(m2_s2[(i+1)%3]);
				pna_s3[i] <= n1_s2[(i+1)%3] ^ n2_s2[(i+2)%3];
				pnb_s3[i] <= n1_s2[(i+2)%3] ^ n2_s2[(i+1)%3];
			end
		end
	end

	// ---------------- S4: cross product
	logic signed [CRW-1:0] va [3];
	logic signed [CRW-1:0] vb [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i] = {2'b00, pma_s3[i]};
			vb[i] = {2'b00, pmb_s3[i]};
			if (pna_s3[i]) va[i] = -va[i];
			if (pnb_s3[i]) vb[i] = -vb[i];
		end
	end

	logic                  v_s4;
	logic signed [CRW-1:0] cr_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) cr_s4[i] <= va[i] - vb[i];
		end
	end

	// ---------------- S5: shrink the cross product, flag a degenerate triangle
	logic [CW-1:0]    mc  [3];
	logic [CW-1:0]    om2;
	logic [SH2_W-1:0] sh2;

	always_comb begin
		om2 = '0;
		for (int i = 0; i < 3; i++) begin
			mc[i] = cr_s4[i][CRW-1] ? CW'(-cr_s4[i]) : CW'(cr_s4[i]);
			om2   = om2 | mc[i];
		end
		sh2 = '0;
		for (int b = LIM; b < CW; b++) begin
			if (om2[b]) sh2 = SH2_W'(b - LIM + 1);
		end
	end

	logic                v_s5;
	logic [2:0][LIM-1:0] cm_s5;
	logic [2:0]          cn_s5;
	logic                dg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				cm_s5[i] <= LIM'(mc[i] >> sh2);
				cn_s5[i] <= cr_s4[i][CRW-1];
			end
			dg_s5 <= (om2 == '0);
		end
	end

	// ---------------- S6: squares
	logic                v_s6;
	logic [2*LIM-1:0]    sq_s6 [3];
	logic [2:0][LIM-1:0] cm_s6;
	logic [2:0]          cn_s6;
	logic                dg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= (2*LIM)'(cm_s5[i]) * (2*LIM)'(cm_s5[i]);
			end
			cm_s6 <= cm_s5;
			cn_s6 <= cn_s5;
			dg_s6 <= dg_s5;
		end
	end

	// ---------------- S7: sum of squares
	logic                v_s7;
	logic [SQW-1:0]      ss_s7;
	logic [2:0][LIM-1:0] cm_s7;
	logic [2:0]          cn_s7;
	logic                dg_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ss_s7 <= SQW'(sq_s6[0]) + SQW'(sq_s6[1]) + SQW'(sq_s6[2]);
			cm_s7 <= cm_s6;
			cn_s7 <= cn_s6;
			dg_s7 <= dg_s6;
		end
	end

	// ---------------- centroid: (|sum| + 1) / 3, operand in S2, reciprocal product in S3,
	// then carried along to S7
	logic [SW-1:0]   msum    [3];
	logic [XW-1:0]   cx_s2   [3];
	logic            csg_s2  [3];
	logic [VW-1:0]   cvol_s2;
	logic [2*XW-1:0] cprod   [3];
	logic [W-1:0]    cq_s    [3:7][3];
	logic            csg_s   [3:7][3];
	logic [VW-1:0]   cvol_s  [3:7];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			msum[i]  = sum_s1[i][SW-1] ? SW'(-sum_s1[i]) : SW'(sum_s1[i]);
			cprod[i] = (2*XW)'(cx_s2[i]) * (2*XW)'(RCP_3);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				cx_s2[i]    <= XW'(msum[i]) + XW'(1);
				csg_s2[i]   <= sum_s1[i][SW-1];
				cq_s[3][i]  <= cprod[i][RCP_SH +: W];
				csg_s[3][i] <= csg_s2[i];
			end
			cvol_s2   <= vol_s1;
			cvol_s[3] <= cvol_s2;
			for (int k = 3; k < 7; k++) begin
				for (int i = 0; i < 3; i++) begin
					cq_s[k+1][i]  <= cq_s[k][i];
					csg_s[k+1][i] <= csg_s[k][i];
				end
				cvol_s[k+1] <= cvol_s[k];
			end
		end
	end

	logic [W-1:0] cen7 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cen7[i] = csg_s[7][i] ? -cq_s[7][i] : cq_s[7][i];
		end
	end

	// ---------------- length and normalising division
	tst_pkg::tst_ctrl_t  np_ctrl;
	logic [SIDE_W-1:0]   np_side_in;
	logic [SIDE_W-1:0]   np_side_out;
	logic                np_valid;
	logic [2:0][QW-1:0]  np_quo;

	assign np_ctrl.adv   = adv;
	assign np_ctrl.valid = v_s7;
	assign np_side_in    = {cen7[0], cen7[1], cen7[2], cn_s7, dg_s7, cvol_s[7]};

	tst_norm_pipe #(
		.SIDE_W (SIDE_W)
	) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (np_ctrl),
		.sum      (ss_s7),
		.mag      (cm_s7),
		.side_in  (np_side_in),
		.out_valid(np_valid),
		.quo      (np_quo),
		.side_out (np_side_out)
	);

	logic [W-1:0]  nc_cen [3];
	logic [2:0]    nc_neg;
	logic          nc_dg;
	logic [VW-1:0] nc_vol;
	logic [QW-1:0] qc [3];

	assign {nc_cen[0], nc_cen[1], nc_cen[2], nc_neg, nc_dg, nc_vol} = np_side_out;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc[i] = (np_quo[i] > QW'(tst_pkg::NORM_ONE)) ? QW'(tst_pkg::NORM_ONE) : np_quo[i];
			if (nc_dg) qc[i] = '0;
		end
	end

	// ---------------- S8: clamp the normal, volume times amplitude
	logic          v_s8;
	logic [QW-1:0] qm_s8  [3];
	logic [2:0]    neg_s8;
	logic [W-1:0]  cen_s8 [3];
	logic [VPW-1:0] vp_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= np_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				qm_s8[i]  <= qc[i];
				cen_s8[i] <= nc_cen[i];
			end
			neg_s8 <= nc_neg;
			vp_s8  <= VPW'(nc_vol) * VPW'(amp_q);
		end
	end

	// ---------------- S9: offset product
	logic           v_s9;
	logic [PRW-1:0] pr_s9  [3];
	logic [QW-1:0]  qm_s9  [3];
	logic [2:0]     neg_s9;
	logic [W-1:0]   cen_s9 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pr_s9[i]  <= PRW'(vp_s8) * PRW'(qm_s8[i]);
				qm_s9[i]  <= qm_s8[i];
				cen_s9[i] <= cen_s8[i];
			end
			neg_s9 <= neg_s8;
		end
	end

	// ---------------- S10: round, add, saturate into the output register
	logic [PRW:0]         rnd  [3];
	logic signed [TW-1:0] offs [3];
	logic signed [TW-1:0] tsum [3];
	logic [W-1:0]         tsat [3];
	logic [NW-1:0]        nrm  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i]  = (PRW+1)'(pr_s9[i]) + ((PRW+1)'(1) << 29);
			offs[i] = TW'(rnd[i] >> 30);
			if (neg_s9[i]) offs[i] = -offs[i];
			tsum[i] = {{2{cen_s9[i][W-1]}}, cen_s9[i]} + offs[i];
			if (tsum[i][TW-1:W-1] == '0 || tsum[i][TW-1:W-1] == '1) begin
				tsat[i] = tsum[i][W-1:0];
			end else if (tsum[i][TW-1]) begin
				tsat[i] = {1'b1, {(W-1){1'b0}}};
			end else begin
				tsat[i] = {1'b0, {(W-1){1'b1}}};
			end
			nrm[i] = neg_s9[i] ? -NW'(qm_s9[i]) : NW'(qm_s9[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_data.centroid_x <= cen_s9[0];
			res_data.centroid_y <= cen_s9[1];
			res_data.centroid_z <= cen_s9[2];
			res_data.normal_x   <= nrm[0];
			res_data.normal_y   <= nrm[1];
			res_data.normal_z   <= nrm[2];
			res_data.tip_x      <= tsat[0];
			res_data.tip_y      <= tsat[1];
			res_data.tip_z      <= tsat[2];
		end
	end

	// ---------------- checks
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.normal_x >= -16384 && res_data.normal_x <= 16384
			&& res_data.normal_y >= -16384 && res_data.normal_y <= 16384
			&& res_data.normal_z >= -16384 && res_data.normal_z <= 16384))
		else $error("normal component out of range");

	a_flat_tip: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.normal_x == 0 && res_data.normal_y == 0
			&& res_data.normal_z == 0)
		|-> (res_data.tip_x == res_data.centroid_x && res_data.tip_y == res_data.centroid_y
			&& res_data.tip_z == res_data.centroid_z))
		else $error("degenerate triangle tip differs from centroid");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(v_s1) && $stable(v_s7) && $stable(np_valid) && $stable(v_s9)))
		else $error("pipeline moved during a stall");

	a_res_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !v_s9) |=> !res_valid)
		else $error("result beat without a source");

endmodule
`default_nettype wire

>>> sim/triangle_spike_tip_checker.sv
`timescale 1ns / 1ps
module triangle_spike_tip_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          tri_valid,
	input  wire logic                          tri_ready,
	input  wire tst_pkg::tst_in_t              tri_data,
	input  wire logic                          res_valid,
	input  wire logic                          res_ready,
	input  wire tst_pkg::tst_out_t             res_data,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [tst_pkg::AMP_WIDTH-1:0] cfg_data,
	output int                                 fail_count,
	output int                                 pending
);

	localparam int CW  = tst_pkg::COORD_WIDTH;
	localparam int NWD = tst_pkg::NORM_WIDTH;
	localparam int AW  = tst_pkg::AMP_WIDTH;

	logic [AW-1:0] gain;
	tst_pkg::tst_out_t spike_queue[$];

	function automatic longint unsigned absval(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint signed_of(longint unsigned m, bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic tst_pkg::tst_out_t spike_of(tst_pkg::tst_in_t t, logic [AW-1:0] amp);
		longint p[9], cen[3], d1[3], d2[3], cr[3], nrm[3];
		longint s, tv, hi, lo;
		longint unsigned m, sum, len, num, q, prod, off;
		int sh;
		tst_pkg::tst_out_t o;
		hi = (longint'(1) << (CW - 1)) - 1;
		lo = -hi - 1;
		p = '{t.ax, t.ay, t.az, t.bx, t.by_coord, t.bz, t.cx, t.cy, t.cz};
		for (int i = 0; i < 3; i++) begin
			s = p[i] + p[3+i] + p[6+i];
			cen[i] = signed_of((absval(s) + 1) / 3, s < 0);
			d1[i] = p[3+i] - p[i];
			d2[i] = p[6+i] - p[i];
		end
		m = 0;
		for (int i = 0; i < 3; i++) begin
			if (absval(d1[i]) > m) m = absval(d1[i]);
			if (absval(d2[i]) > m) m = absval(d2[i]);
		end
		sh = 0;
		while (sh < 63 && (m >> sh) >= (64'd1 << tst_pkg::LIMIT_BITS)) sh++;
		for (int i = 0; i < 3; i++) begin
			d1[i] = signed_of(absval(d1[i]) >> sh, d1[i] < 0);
			d2[i] = signed_of(absval(d2[i]) >> sh, d2[i] < 0);
		end
		cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
		cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
		cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
		if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
			nrm = '{0, 0, 0};
		end else begin
			m = 0;
			for (int i = 0; i < 3; i++) if (absval(cr[i]) > m) m = absval(cr[i]);
			sh = 0;
			while (sh < 63 && (m >> sh) >= (64'd1 << tst_pkg::LIMIT_BITS)) sh++;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				cr[i] = signed_of(absval(cr[i]) >> sh, cr[i] < 0);
				sum += absval(cr[i]) * absval(cr[i]);
			end
			len = root_floor(sum);
			for (int i = 0; i < 3; i++) begin
				num = absval(cr[i]) * tst_pkg::NORM_ONE;
				q = (2 * num + len) / (2 * len);
				if (q > tst_pkg::NORM_ONE) q = tst_pkg::NORM_ONE;
				nrm[i] = signed_of(q, cr[i] < 0);
			end
		end
		for (int i = 0; i < 3; i++) begin
			prod = longint'(t.volume) * longint'(amp) * absval(nrm[i]);
			off = (prod + (64'd1 << 29)) >> 30;
			tv = cen[i] + signed_of(off, nrm[i] < 0);
			if (tv > hi) tv = hi;
			if (tv < lo) tv = lo;
			p[i] = tv;
		end
		o.centroid_x = CW'(cen[0]); o.centroid_y = CW'(cen[1]); o.centroid_z = CW'(cen[2]);
		o.normal_x = NWD'(nrm[0]); o.normal_y = NWD'(nrm[1]); o.normal_z = NWD'(nrm[2]);
		o.tip_x = CW'(p[0]); o.tip_y = CW'(p[1]); o.tip_z = CW'(p[2]);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tst_pkg::tst_out_t want;
		if (!arst_n) begin
			gain <= tst_pkg::AMP_RESET;
			fail_count <= 0;
			pending <= 0;
			spike_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) gain <= cfg_data;
			if (tri_valid && tri_ready)
				spike_queue.insert(spike_queue.size(), spike_of(tri_data, gain));
			if (res_valid && res_ready) begin
				if (spike_queue.size() == 0) begin
					if (fail_count < 10) $display("unexpected result beat %h", res_data);
					fail_count <= fail_count + 1;
				end else begin
					want = spike_queue.pop_front();
					if (want !== res_data) begin
						if (fail_count < 10)
							$display("mismatch: expected %h actual %h", want, res_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= spike_queue.size();
		end
	end
endmodule

>>> sim/triangle_spike_tip_unit_tb.sv
`timescale 1ns / 1ps
module triangle_spike_tip_unit_tb;

	localparam int PIPE_DEPTH = 56;
	localparam int CW = tst_pkg::COORD_WIDTH;
	localparam longint C_MAX = (longint'(1) << (CW - 1)) - 1;
	localparam longint C_MIN = -C_MAX - 1;

	logic clk = 0;
	logic arst_n = 0;
	logic tri_valid = 0, tri_ready, res_valid, res_ready = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [tst_pkg::AMP_WIDTH-1:0] cfg_data = '0;
	tst_pkg::tst_in_t tri_data = '0;
	tst_pkg::tst_out_t res_data;
	int fail_count, pending;
	int send_idle = 0, recv_stall = 0;

	always #10 clk = ~clk;

	triangle_spike_tip_unit dut (
		.clk(clk), .arst_n(arst_n),
		.tri_valid(tri_valid), .tri_ready(tri_ready), .tri_data(tri_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	triangle_spike_tip_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.tri_valid(tri_valid), .tri_ready(tri_ready), .tri_data(tri_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) res_ready <= ($urandom_range(99) >= recv_stall);

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(4))
			0: return CW'(C_MAX - longint'($urandom_range(3)));
			1: return CW'(C_MIN + longint'($urandom_range(3)));
			2: return CW'(longint'($urandom_range(2000)) - 1000);
			default: return CW'($urandom);
		endcase
	endfunction

	// valid stays high between back-to-back beats; drop it only for idle cycles
	task automatic send_triangle(tst_pkg::tst_in_t t);
		if ($urandom_range(99) < send_idle) begin
			tri_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		tri_valid <= 1;
		tri_data <= t;
		do @(posedge clk); while (!tri_ready);
	endtask

	task automatic drain();
		tri_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	task automatic write_gain(logic [tst_pkg::AMP_WIDTH-1:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic random_triangle(int n);
		tst_pkg::tst_in_t t;
		for (int i = 0; i < n; i++) begin
			t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord(), rand_coord(), 16'($urandom)};
			// copy vertices now and then to hit degenerate cases
			if ($urandom_range(9) == 0) begin
				t.bx = t.ax; t.by_coord = t.ay; t.bz = t.az;
			end
			if ($urandom_range(7) == 0) t.volume = $urandom_range(1) ? 16'hffff : 16'h0;
			send_triangle(t);
		end
	endtask

	initial begin
		tst_pkg::tst_in_t t;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: unit triangle, degenerate, extremes
		t = '0; t.bx = 24'd256; t.cy = 24'd256; t.volume = 16'hffff;
		send_triangle(t);
		t = '0; t.volume = 16'h8000;
		send_triangle(t);
		t = '0; t.bx = 24'd100; t.by_coord = 24'd100; t.cx = 24'd200; t.cy = 24'd200;
		send_triangle(t);
		t = {24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h7fffff,
			24'h7fffff, 24'h800000, 24'h7fffff, 16'hffff};
		send_triangle(t);
		t = {24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h800000, 24'h800000,
			24'h800000, 24'h7fffff, 24'h800000, 16'hffff};
		send_triangle(t);
		t = {24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
			24'h800000, 24'h800000, 24'h800000, 16'h0001};
		send_triangle(t);
		t = '0; t.cx = 24'd1; t.by_coord = 24'd1; t.az = 24'hffffff; t.volume = 16'h1234;
		send_triangle(t);
		random_triangle(12);
		drain();
		write_gain(13'd5120);
		random_triangle(60);
		drain();
		write_gain(13'd0);
		send_idle = 56;
		random_triangle(60);
		drain();
		write_gain(13'h1fff);
		send_idle = 0; recv_stall = 56;
		random_triangle(80);
		drain();
		write_gain(13'($urandom_range(5120)));
		send_idle = 7; recv_stall = 7;
		random_triangle(100);
		drain();
		write_gain(13'd1280);
		send_idle = 56; recv_stall = 56;
		random_triangle(100);
		send_idle = 0; recv_stall = 0;
		random_triangle(120);
		drain();
		if (fail_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end
endmodule
